// ===== hw/rtl/sapd_pkg.sv =====
// Shared types, constants and symbol decode for the sync and PWM symbol demodulator.
package sapd_pkg;

  localparam int SYNC_WIDTH_DEF = 16;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_IDX_W      = 1;
  localparam int FRAME_LEN_W    = 4;
  localparam int BYTE_W         = 8;
  localparam int IN_TDATA_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WORD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LEN = 1'b1;

  localparam logic [CFG_DATA_W-1:0]  SYNC_WORD_RST = 16'h8CEF;
  localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RST = 4'd4;

  // thermometer chip patterns, first chip in the top bit
  localparam logic [3:0] CHIPS_SYM0 = 4'b1000;
  localparam logic [3:0] CHIPS_SYM1 = 4'b1100;
  localparam logic [3:0] CHIPS_SYM2 = 4'b1110;
  localparam logic [3:0] CHIPS_SYM3 = 4'b1111;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_in_frame;
    logic              symbol_error;
  } sapd_result_t;

  typedef struct packed {
    logic [1:0] sym;
    logic       bad;
  } sapd_sym_t;

  function automatic sapd_sym_t sapd_decode(input logic [3:0] chips);
    sapd_sym_t d;
    d = '0;
    unique case (chips)
      CHIPS_SYM0: d.sym = 2'd0;
      CHIPS_SYM1: d.sym = 2'd1;
      CHIPS_SYM2: d.sym = 2'd2;
      CHIPS_SYM3: d.sym = 2'd3;
      default:    d.bad = 1'b1;
    endcase
    return d;
  endfunction

endpackage

// ===== hw/rtl/sapd_core.sv =====
// Sync hunt, chip shifting and byte assembly; one sample per cycle while take is high.
module sapd_core import sapd_pkg::*; #(
  parameter int SYNC_WIDTH = SYNC_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic                  sample,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  res_valid,
  output sapd_result_t          res
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HUNT,
    PH_DATA
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [SYNC_WIDTH-1:0]  sync_shift_r, sync_shift_nxt;
  logic [3:0]             chip_count_r, chip_count_nxt;
  logic [3:0]             chip_shift_r, chip_shift_nxt;
  logic [BYTE_W-1:0]      byte_accum_r, byte_accum_nxt;
  logic [FRAME_LEN_W-1:0] byte_count_r, byte_count_nxt;
  logic                   error_seen_r, error_seen_nxt;
  logic [CFG_DATA_W-1:0]  sync_word_r;
  logic [FRAME_LEN_W-1:0] frame_len_r;

  logic [SYNC_WIDTH+CFG_DATA_W-1:0] sync_ext;
  logic [SYNC_WIDTH-1:0]  sync_cmp;
  logic [SYNC_WIDTH-1:0]  shifted;
  logic [3:0]             chips;
  sapd_sym_t              dec;
  logic [BYTE_W-1:0]      accum_new;
  logic                   err_new;
  logic [FRAME_LEN_W-1:0] count_inc;
  logic                   last;

  // sync word zero-extended or truncated to the shift register width
  assign sync_ext = {{SYNC_WIDTH{1'b0}}, sync_word_r};
  assign sync_cmp = sync_ext[SYNC_WIDTH-1:0];

  always_comb begin
    shifted   = {(phase_r == PH_HUNT) ? sync_shift_r[SYNC_WIDTH-2:0]
                                      : {(SYNC_WIDTH-1){1'b0}}, sample};
    chips     = {chip_shift_r[2:0], sample};
    dec       = sapd_decode(chips);
    accum_new = byte_accum_r;
    err_new   = error_seen_r;
    if (chip_count_r[1:0] == 2'd3) begin
      accum_new = {byte_accum_r[BYTE_W-3:0], dec.sym};
      err_new   = error_seen_r | dec.bad;
    end
    count_inc = byte_count_r + 4'd1;
    last      = (count_inc == frame_len_r);

    phase_nxt      = phase_r;
    sync_shift_nxt = sync_shift_r;
    chip_count_nxt = chip_count_r;
    chip_shift_nxt = chip_shift_r;
    byte_accum_nxt = byte_accum_r;
    byte_count_nxt = byte_count_r;
    error_seen_nxt = error_seen_r;
    res_valid      = 1'b0;
    res.data_byte     = accum_new;
    res.last_in_frame = last;
    res.symbol_error  = err_new;

    if (take) begin
      unique case (phase_r)
        PH_DATA: begin
          chip_shift_nxt = (chip_count_r[1:0] == 2'd3) ? 4'd0 : chips;
          byte_accum_nxt = accum_new;
          error_seen_nxt = err_new;
          if (chip_count_r == 4'd15) begin
            res_valid      = 1'b1;
            chip_count_nxt = '0;
            byte_accum_nxt = '0;
            error_seen_nxt = 1'b0;
            byte_count_nxt = count_inc;
            if (last) begin
              phase_nxt      = PH_IDLE;
              sync_shift_nxt = '0;
              byte_count_nxt = '0;
            end
          end else begin
            chip_count_nxt = chip_count_r + 4'd1;
          end
        end
        PH_HUNT: begin
          sync_shift_nxt = shifted;
          if (shifted == sync_cmp) phase_nxt = PH_DATA;
        end
        default: begin
          // first high sample opens the hunt and is already compared
          if (sample) begin
            sync_shift_nxt = shifted;
            phase_nxt      = (shifted == sync_cmp) ? PH_DATA : PH_HUNT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      sync_shift_r <= '0;
      chip_count_r <= '0;
      chip_shift_r <= '0;
      byte_accum_r <= '0;
      byte_count_r <= '0;
      error_seen_r <= 1'b0;
      sync_word_r  <= SYNC_WORD_RST;
      frame_len_r  <= FRAME_LEN_RST;
    end else begin
      phase_r      <= phase_nxt;
      sync_shift_r <= sync_shift_nxt;
      chip_count_r <= chip_count_nxt;
      chip_shift_r <= chip_shift_nxt;
      byte_accum_r <= byte_accum_nxt;
      byte_count_r <= byte_count_nxt;
      error_seen_r <= error_seen_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SYNC_WORD: sync_word_r <= cfg_wdata;
          CFG_FRAME_LEN: frame_len_r <= cfg_wdata[FRAME_LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/sapd_out_buf.sv =====
// Two-entry output register with skid stage; input ready is registered.
module sapd_out_buf import sapd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  sapd_result_t push_data,
  output logic         can_take,
  output logic         out_valid,
  input  logic         out_ready,
  output sapd_result_t out_data
);

  logic         main_valid_r, main_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  sapd_result_t main_r, main_nxt;
  sapd_result_t skid_r, skid_nxt;
  logic         pop;

  assign pop       = main_valid_r & out_ready;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;
  assign can_take  = ~skid_valid_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_nxt       = push_data;
        skid_valid_nxt = push;
      end else begin
        main_nxt       = push_data;
        main_valid_nxt = push;
      end
    end else if (push) begin
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ===== hw/rtl/sync_and_pwm_symbol_demodulator.sv =====
// A byte enters the output buffer (main register, or skid when main is held) as its sixteenth chip is accepted.
// Throughput: one line sample per cycle while in_tready is high; the decode state updates on each accepted item.
// in_tready drops only while both output entries (register and skid) hold unread bytes.
// Reset (rst_n low, synchronous): idle, counters cleared, output empty,
// sync word 0x8CEF and frame length 4.
module sync_and_pwm_symbol_demodulator import sapd_pkg::*; #(
  parameter int SYNC_WIDTH = SYNC_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // [0] line_sample, [7:1] zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [BYTE_W-1:0]     out_tdata,  // [7:0] data_byte
  output logic                  out_tlast,
  output logic                  out_tuser,  // [0] symbol_error
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic         take;
  logic         res_valid;
  sapd_result_t res;
  sapd_result_t out_res;

  assign take = in_tvalid & in_tready;

  sapd_core #(
    .SYNC_WIDTH (SYNC_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .sample    (in_tdata[0]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .res_valid (res_valid),
    .res       (res)
  );

  sapd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .can_take  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = out_res.data_byte;
  assign out_tlast = out_res.last_in_frame;
  assign out_tuser = out_res.symbol_error;

endmodule
